// File: rtl/core/cesu_pkg.sv
// ----------------------------------------------------------------------------
// cesu_pkg: shared types and constants for the CESU-8 to UCS-2 decoder
// Holds the escape codes, the decode result bundle and the result queue entry.
// ----------------------------------------------------------------------------
package cesu_pkg;

   // Escape code bases
   localparam logic [15:0] ESC_BYTE  = 16'hEF00;  // raw byte escape
   localparam logic [15:0] ESC_TRAIL = 16'hEF80;  // pending trail byte
   localparam logic [15:0] ESC_LEAD2 = 16'hEFC0;  // pending two-byte lead
   localparam logic [15:0] ESC_LEAD3 = 16'hEFE0;  // pending three-byte lead

   // Sequence validity limits
   localparam logic [7:0]  LEAD2_MIN   = 8'hC2;
   localparam logic [7:0]  LEAD3_MIN   = 8'hE0;
   localparam logic [7:0]  LEAD_LIMIT  = 8'hF0;
   localparam logic [7:0]  TRAIL_LOW   = 8'hA0;
   localparam logic [7:0]  TRAIL_HIGH  = 8'hBD;
   localparam logic [15:0] PC_E000     = 16'hE000;
   localparam logic [15:0] PC_FFC0     = 16'hFFC0;

   // Most results one byte can cause
   localparam int MAX_RESULTS = 3;

   // Result queue geometry
   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   // One queued result
   typedef struct packed {
      logic [15:0] code_unit;
      logic        last_of_run;
   } rsp_entry_type;

   // Decoder output for one input transaction
   typedef struct packed {
      logic [1:0]                   count;
      logic [MAX_RESULTS-1:0][15:0] unit;
      logic [1:0]                   trail_next;
      logic [15:0]                  partial_next;
   } dec_out_type;

endpackage

// File: rtl/core/cesu_decode.sv
// ----------------------------------------------------------------------------
// cesu_decode: byte decode step
// From the pending sequence state and one input byte, produces up to three
// code units and the next sequence state.
// ----------------------------------------------------------------------------
module cesu_decode (
   input  logic [7:0]           data_byte,
   input  logic                 end_of_input,
   input  logic [1:0]           trail_remaining,
   input  logic [15:0]          partial_code,
   output cesu_pkg::dec_out_type dec
);

   logic [1:0]  dis_n;
   logic [15:0] dis_0;
   logic [15:0] dis_1;
   logic        tail_n;
   logic [15:0] tail_u;
   logic        f_emit;
   logic [15:0] f_unit;
   logic [1:0]  f_trail;
   logic [15:0] f_partial;
   logic        bad;

   // Fresh lead decode of the byte
   always_comb begin
      f_emit    = 1'b0;
      f_unit    = 16'h0000;
      f_trail   = 2'd0;
      f_partial = 16'h0000;
      if (!data_byte[7]) begin
         f_emit = 1'b1;
         f_unit = {8'h00, data_byte};
      end else if (data_byte < cesu_pkg::LEAD2_MIN || data_byte >= cesu_pkg::LEAD_LIMIT) begin
         f_emit = 1'b1;
         f_unit = cesu_pkg::ESC_BYTE | {8'h00, data_byte};
      end else if (data_byte < cesu_pkg::LEAD3_MIN) begin
         f_trail   = 2'd1;
         f_partial = {5'b0, data_byte[4:0], 6'b0};
      end else begin
         f_trail   = 2'd2;
         f_partial = {data_byte[3:0], 12'b0};
      end
   end

   // Escapes for the pending sequence
   always_comb begin
      dis_n = 2'd0;
      dis_0 = 16'h0000;
      dis_1 = 16'h0000;
      if (trail_remaining == 2'd2) begin
         dis_n = 2'd1;
         dis_0 = cesu_pkg::ESC_LEAD3 | {12'h000, partial_code[15:12]};
      end else if (trail_remaining == 2'd1) begin
         if (partial_code[15:11] == 5'd0) begin
            dis_n = 2'd1;
            dis_0 = cesu_pkg::ESC_LEAD2 | {11'h000, partial_code[10:6]};
         end else begin
            dis_n = 2'd2;
            dis_0 = cesu_pkg::ESC_LEAD3 | {12'h000, partial_code[15:12]};
            dis_1 = cesu_pkg::ESC_TRAIL | {10'h000, partial_code[11:6]};
         end
      end
   end

   // Trail byte check: overlong, reserved escape range, and U+FFFE/FFFF
   assign bad = (data_byte[7:6] != 2'b10) ||
                (trail_remaining == 2'd2 && partial_code == 16'h0000 &&
                 data_byte < cesu_pkg::TRAIL_LOW) ||
                (trail_remaining == 2'd2 && partial_code == cesu_pkg::PC_E000 &&
                 data_byte > cesu_pkg::TRAIL_HIGH) ||
                (trail_remaining == 2'd1 && partial_code == cesu_pkg::PC_FFC0 &&
                 data_byte > cesu_pkg::TRAIL_HIGH);

   // Step selection
   always_comb begin
      logic [1:0] use_dis;
      use_dis          = 2'd0;
      tail_n           = 1'b0;
      tail_u           = 16'h0000;
      dec.trail_next   = trail_remaining;
      dec.partial_next = partial_code;
      if (end_of_input) begin
         use_dis          = dis_n;
         dec.trail_next   = 2'd0;
         dec.partial_next = 16'h0000;
      end else if (trail_remaining != 2'd0) begin
         if (bad) begin
            use_dis          = dis_n;
            tail_n           = f_emit;
            tail_u           = f_unit;
            dec.trail_next   = f_trail;
            dec.partial_next = f_partial;
         end else if (trail_remaining == 2'd2) begin
            dec.trail_next   = 2'd1;
            dec.partial_next = partial_code | {4'b0, data_byte[5:0], 6'b0};
         end else begin
            tail_n           = 1'b1;
            tail_u           = partial_code | {10'b0, data_byte[5:0]};
            dec.trail_next   = 2'd0;
            dec.partial_next = 16'h0000;
         end
      end else begin
         tail_n           = f_emit;
         tail_u           = f_unit;
         dec.trail_next   = f_trail;
         dec.partial_next = f_partial;
      end

      // Pack escapes first, then the tail result
      dec.count = use_dis + {1'b0, tail_n};
      dec.unit  = '0;
      case (use_dis)
         2'd0: begin
            dec.unit[0] = tail_u;
         end
         2'd1: begin
            dec.unit[0] = dis_0;
            dec.unit[1] = tail_u;
         end
         default: begin
            dec.unit[0] = dis_0;
            dec.unit[1] = dis_1;
            dec.unit[2] = tail_u;
         end
      endcase
   end

endmodule

// File: rtl/core/cesu_queue.sv
// ----------------------------------------------------------------------------
// cesu_queue: result queue
// Small register queue that takes up to three results per cycle and hands
// out one per cycle on a valid/ready channel.
// ----------------------------------------------------------------------------
module cesu_queue (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic [1:0]                               push_count,
   input  cesu_pkg::rsp_entry_type [cesu_pkg::MAX_RESULTS-1:0] push_data,
   output logic                                     room,
   output logic                                     out_valid,
   input  logic                                     out_ready,
   output cesu_pkg::rsp_entry_type                  out_data
);

   cesu_pkg::rsp_entry_type mem_ff [cesu_pkg::QUEUE_DEPTH];
   logic [cesu_pkg::PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [cesu_pkg::PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [cesu_pkg::CNT_W-1:0] count_ff, count_in;
   logic                       pop;

   assign pop       = out_valid && out_ready;
   assign out_valid = count_ff != '0;
   assign out_data  = mem_ff[rd_ptr_ff];
   // Room for a full burst of results
   assign room      = count_ff <= cesu_pkg::CNT_W'(cesu_pkg::QUEUE_DEPTH - cesu_pkg::MAX_RESULTS);

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff + cesu_pkg::PTR_W'(push_count);
      rd_ptr_in = rd_ptr_ff + cesu_pkg::PTR_W'(pop);
      count_in  = count_ff + cesu_pkg::CNT_W'(push_count) - cesu_pkg::CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry writes, up to three consecutive slots
   always_ff @(posedge clock) begin
      for (int i = 0; i < cesu_pkg::MAX_RESULTS; i++) begin
         if (2'(i) < push_count) begin
            mem_ff[wr_ptr_ff + cesu_pkg::PTR_W'(i)] <= push_data[i];
         end
      end
   end

endmodule

// File: rtl/core/cesu8_to_ucs2_decoder.sv
// ----------------------------------------------------------------------------
// cesu8_to_ucs2_decoder: CESU-8 style byte stream to 16-bit code units
// Top level: sequence state, decode step and result queue.
// ----------------------------------------------------------------------------
// One byte is taken per cycle whenever the four-entry result queue has room
// for three results (at most one result already waiting). Each byte is
// decoded in the cycle it is accepted and its zero to three results enter
// the queue together; results leave one per cycle while rsp_ready is high, so
// a byte stream that yields one result per byte runs at one byte per cycle,
// and a burst of escapes after a broken sequence holds off input as it drains.
// Setting end_of_input flushes a pending partial sequence as escapes.
// rsp_last_of_run marks the final result caused by one input transaction.
module cesu8_to_ucs2_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_input,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_code_unit,
   output logic        rsp_last_of_run
);

   logic [1:0]  trail_ff, trail_in;
   logic [15:0] partial_ff, partial_in;
   logic        accept;
   logic [1:0]  push_count;
   cesu_pkg::dec_out_type   dec;
   cesu_pkg::rsp_entry_type [cesu_pkg::MAX_RESULTS-1:0] push_data;
   cesu_pkg::rsp_entry_type out_data;

   assign accept = req_valid && req_ready;

   // Decode step
   cesu_decode u_decode (
      .data_byte       (req_data_byte),
      .end_of_input    (req_end_of_input),
      .trail_remaining (trail_ff),
      .partial_code    (partial_ff),
      .dec             (dec)
   );

   // Sequence state
   always_comb begin
      trail_in   = accept ? dec.trail_next   : trail_ff;
      partial_in = accept ? dec.partial_next : partial_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trail_ff   <= 2'd0;
         partial_ff <= 16'h0000;
      end else begin
         trail_ff   <= trail_in;
         partial_ff <= partial_in;
      end
   end

   // Results of this transaction, last one flagged
   always_comb begin
      push_count = accept ? dec.count : 2'd0;
      for (int i = 0; i < cesu_pkg::MAX_RESULTS; i++) begin
         push_data[i].code_unit   = dec.unit[i];
         push_data[i].last_of_run = (2'(i + 1) == dec.count);
      end
   end

   cesu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push_data  (push_data),
      .room       (req_ready),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_data   (out_data)
   );

   assign rsp_code_unit   = out_data.code_unit;
   assign rsp_last_of_run = out_data.last_of_run;

endmodule

// File: dv/cesu8_to_ucs2_decoder_tb.sv
// ----------------------------------------------------------------------------
// cesu8_to_ucs2_decoder_tb: self-checking bench for the CESU-8 to UCS-2 decoder
// Drives directed and random byte streams with bursty input and a stalling
// receiver, predicts every code unit in a scoreboard and checks each result.
// ----------------------------------------------------------------------------
module cesu8_to_ucs2_decoder_tb;

   localparam int IDLE_LIMIT   = 2000;  // cycles without any transaction
   localparam int RANDOM_ITEMS = 500;
   localparam int DRAIN_CYCLES = 10;

   // Shapes of random byte sequences
   typedef enum int {
      SEQ_ASCII, SEQ_TWO_BYTE, SEQ_THREE_BYTE, SEQ_NOISE, SEQ_BROKEN, SEQ_FLUSH
   } seq_kind_type;

   // Receiver stall patterns
   typedef enum int {RX_OPEN, RX_HALF, RX_CHOKED, RX_PERIODIC} rx_mode_type;

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic [7:0]  req_data_byte    = 8'h00;
   logic        req_end_of_input = 1'b0;
   logic        rsp_ready        = 1'b0;
   logic        req_ready;
   logic        rsp_valid;
   logic [15:0] rsp_code_unit;
   logic        rsp_last_of_run;

   // Decoder state tracking and queue of expected code units
   class unit_scoreboard;
      logic [1:0]              trail_left;
      logic [15:0]             partial;
      cesu_pkg::rsp_entry_type expected_units[$];
      logic [15:0]             run_units[$];
      int                      errors;

      function new();
         trail_left = 2'd0;
         partial    = 16'h0000;
         errors     = 0;
      endfunction

      function void report(string msg);
         errors++;
         if (errors <= 10) $display("%s", msg);
      endfunction

      // Escapes for the bytes of a pending sequence, then clear it
      function void dismiss_pending();
         if (trail_left == 2'd2) begin
            run_units.push_back(cesu_pkg::ESC_LEAD3 | {12'h000, partial[15:12]});
         end else if (trail_left == 2'd1) begin
            if (partial < 16'h0800) begin
               run_units.push_back(cesu_pkg::ESC_LEAD2 | {11'h000, partial[10:6]});
            end else begin
               run_units.push_back(cesu_pkg::ESC_LEAD3 | {12'h000, partial[15:12]});
               run_units.push_back(cesu_pkg::ESC_TRAIL | {10'h000, partial[11:6]});
            end
         end
         trail_left = 2'd0;
         partial    = 16'h0000;
      endfunction

      // Byte seen with no sequence pending
      function void decode_lead(logic [7:0] b);
         if (b < 8'h80) begin
            run_units.push_back({8'h00, b});
         end else if (b < cesu_pkg::LEAD2_MIN || b >= cesu_pkg::LEAD_LIMIT) begin
            run_units.push_back(cesu_pkg::ESC_BYTE | {8'h00, b});
         end else if (b < cesu_pkg::LEAD3_MIN) begin
            trail_left = 2'd1;
            partial    = {5'b0, b[4:0], 6'b0};
         end else begin
            trail_left = 2'd2;
            partial    = {b[3:0], 12'h000};
         end
      endfunction

      // Accepted input transaction: predict its code units
      function void note_byte(logic [7:0] b, logic eoi);
         logic                    bad;
         logic [15:0]             trail_bits;
         cesu_pkg::rsp_entry_type entry;
         run_units.delete();
         if (eoi) begin
            dismiss_pending();
         end else if (trail_left != 2'd0) begin
            bad = (b[7:6] != 2'b10) ||
                  (trail_left == 2'd2 && partial == 16'h0000 &&
                   b < cesu_pkg::TRAIL_LOW) ||
                  (trail_left == 2'd2 && partial == cesu_pkg::PC_E000 &&
                   b > cesu_pkg::TRAIL_HIGH) ||
                  (trail_left == 2'd1 && partial == cesu_pkg::PC_FFC0 &&
                   b > cesu_pkg::TRAIL_HIGH);
            if (bad) begin
               dismiss_pending();
               decode_lead(b);
            end else begin
               trail_left = trail_left - 2'd1;
               trail_bits = {10'h000, b[5:0]};
               partial    = partial | (trail_bits << (6 * trail_left));
               if (trail_left == 2'd0) begin
                  run_units.push_back(partial);
                  partial = 16'h0000;
               end
            end
         end else begin
            decode_lead(b);
         end
         foreach (run_units[i]) begin
            entry.code_unit   = run_units[i];
            entry.last_of_run = (i == run_units.size() - 1);
            expected_units.push_back(entry);
         end
      endfunction

      // Accepted result transaction: compare with the oldest prediction
      function void check_unit(logic [15:0] code, logic last);
         cesu_pkg::rsp_entry_type want;
         if (expected_units.size() == 0) begin
            report($sformatf("ERROR: unexpected result code_unit=%h last_of_run=%b",
                             code, last));
         end else begin
            want = expected_units.pop_front();
            if (want.code_unit !== code || want.last_of_run !== last)
               report($sformatf("ERROR: code_unit exp %h got %h, last_of_run exp %b got %b",
                                want.code_unit, code, want.last_of_run, last));
         end
      endfunction
   endclass

   unit_scoreboard units;
   int             burst_left  = 0;
   int             items_sent  = 0;
   int             idle_cycles = 0;
   int             rx_cycle    = 0;
   rx_mode_type    rx_mode     = RX_OPEN;

   cesu8_to_ucs2_decoder u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_end_of_input (req_end_of_input),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_code_unit    (rsp_code_unit),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Present one transaction; bursts of random length, mostly with gaps between them
   task automatic drive_item(logic [7:0] b, logic eoi);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      req_valid        <= 1'b1;
      req_data_byte    <= b;
      req_end_of_input <= eoi;
      // handshake is sampled mid-cycle, accepted at the next rising edge
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      units.note_byte(b, eoi);
      @(posedge clock);
      burst_left--;
      items_sent++;
   endtask

   task automatic send_byte(logic [7:0] b);
      drive_item(b, 1'b0);
   endtask

   task automatic send_flush();
      drive_item(8'($urandom_range(0, 255)), 1'b1);
   endtask

   function automatic logic [7:0] any_trail();
      return 8'h80 | 8'($urandom_range(0, 63));
   endfunction

   // One random sequence: mostly well formed, some noise and broken ones
   task automatic send_random_sequence();
      int           pick;
      seq_kind_type kind;
      logic [7:0]   lead;
      logic [7:0]   mid;
      pick = $urandom_range(0, 99);
      kind = (pick < 20) ? SEQ_ASCII :
             (pick < 40) ? SEQ_TWO_BYTE :
             (pick < 68) ? SEQ_THREE_BYTE :
             (pick < 80) ? SEQ_NOISE :
             (pick < 92) ? SEQ_BROKEN : SEQ_FLUSH;
      case (kind)
         SEQ_ASCII: send_byte(8'($urandom_range(0, 127)));
         SEQ_TWO_BYTE: begin
            send_byte(8'($urandom_range(cesu_pkg::LEAD2_MIN, 8'hDF)));
            send_byte(any_trail());
         end
         SEQ_THREE_BYTE: begin
            lead = 8'($urandom_range(cesu_pkg::LEAD3_MIN, 8'hEF));
            mid  = (lead == cesu_pkg::LEAD3_MIN) ?
                      8'($urandom_range(cesu_pkg::TRAIL_LOW, 8'hBF)) :
                   (lead == 8'hEE) ?
                      8'($urandom_range(8'h80, cesu_pkg::TRAIL_HIGH)) :
                   any_trail();
            send_byte(lead);
            send_byte(mid);
            send_byte((lead == 8'hEF && mid == 8'hBF) ?
                      8'($urandom_range(8'h80, cesu_pkg::TRAIL_HIGH)) : any_trail());
         end
         SEQ_NOISE: send_byte(8'($urandom_range(0, 255)));
         SEQ_BROKEN: begin
            case ($urandom_range(0, 3))
               0: begin
                  send_byte(cesu_pkg::LEAD3_MIN);
                  send_byte(8'($urandom_range(8'h80, 8'h9F)));
               end
               1: begin
                  send_byte(8'hEE);
                  send_byte(8'($urandom_range(8'hBE, 8'hBF)));
               end
               2: begin
                  send_byte(8'hEF);
                  send_byte(8'hBF);
                  send_byte(8'($urandom_range(8'hBE, 8'hBF)));
               end
               default: begin
                  lead = 8'($urandom_range(cesu_pkg::LEAD2_MIN, 8'hEF));
                  send_byte(lead);
                  if (lead >= cesu_pkg::LEAD3_MIN && $urandom_range(0, 1))
                     send_byte(any_trail());
                  send_byte(8'($urandom_range(0, 255)));
               end
            endcase
         end
         default: begin
            if ($urandom_range(0, 3) != 0) begin
               lead = 8'($urandom_range(cesu_pkg::LEAD2_MIN, 8'hEF));
               send_byte(lead);
               if (lead >= cesu_pkg::LEAD3_MIN && $urandom_range(0, 1))
                  send_byte(any_trail());
            end
            send_flush();
         end
      endcase
   endtask

   // Receiver stalls, in a pattern that is redrawn at random during the run
   always @(posedge clock) begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle % 64 == 0) rx_mode <= rx_mode_type'($urandom_range(0, 3));
      case (rx_mode)
         RX_OPEN:   rsp_ready <= 1'b1;
         RX_HALF:   rsp_ready <= 1'($urandom_range(0, 1));
         RX_CHOKED: rsp_ready <= ($urandom_range(0, 3) == 0);
         default:   rsp_ready <= (rx_cycle % 5 != 0);
      endcase
   end

   // Result monitor and watchdog, sampled mid-cycle
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) units.check_unit(rsp_code_unit, rsp_last_of_run);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("ERROR: no transaction for %0d cycles", IDLE_LIMIT);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // Main sequence
   initial begin
      int random_start;
      units = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes and each rejected or special form
      send_byte(8'h00);
      send_byte(8'h7F);
      send_byte(8'h80);                       // stray trail byte
      send_byte(8'hC1);                       // overlong two-byte lead
      send_byte(8'hFF);
      send_flush();                           // nothing pending
      send_byte(8'hC2); send_byte(8'h80);     // U+0080
      send_byte(8'hDF); send_byte(8'hBF);     // U+07FF
      send_byte(8'hE0); send_byte(8'hA0); send_byte(8'h80);   // U+0800
      send_byte(8'hE0); send_byte(8'h9F);     // overlong three-byte form
      send_byte(8'hED); send_byte(8'hA0); send_byte(8'h80);   // surrogate
      send_byte(8'hEE); send_byte(8'hBE);     // lands in reserved range
      send_byte(8'hEF); send_byte(8'hBF); send_byte(8'hBF);   // U+FFFF
      send_byte(8'hE1); send_byte(8'h80); send_byte(8'h41);   // break after trail
      send_byte(8'hD0); send_flush();         // lead only
      send_byte(8'hE5); send_byte(8'h90); send_flush();       // lead and trail

      random_start = items_sent;
      while (items_sent - random_start < RANDOM_ITEMS) send_random_sequence();
      req_valid <= 1'b0;

      while (units.expected_units.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (units.errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// File: cesu8_to_ucs2_decoder.f
rtl/core/cesu_pkg.sv
rtl/core/cesu_decode.sv
rtl/core/cesu_queue.sv
rtl/core/cesu8_to_ucs2_decoder.sv
dv/cesu8_to_ucs2_decoder_tb.sv
